[rtl/pmarc_pkg.sv]
// Shared types, constants and helper functions of the power meter record checker.
// Used by the front parser, the record queue, the back end and the top level.
package pmarc_pkg;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_LEN  = 3'b001,
        PH_TYPE = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    // Back end sequencer steps, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCALE  = 7'b0000010,
        ST_MUL_VI = 7'b0000100,
        ST_MUL_PF = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_DIFF   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_back_state;

    // One complete manufacturer record body, byte k at index k.
    typedef logic [7:0][7:0] t_rec;

    localparam logic [7:0]  MFR_TYPE        = 8'hFF;
    localparam logic [7:0]  MFR_LEN         = 8'd8;
    // floor(x / 10) = (x * 52429) >> 19 for every 12-bit x.
    localparam logic [15:0] VOLT_RECIP      = 16'd52429;
    // floor(x / 100) = (x * 1374389535) >> 37 for every 32-bit x.
    localparam logic [30:0] DIV100_RECIP    = 31'd1374389535;
    localparam logic [31:0] ZERO_WATT_LIMIT = 32'd5;

    // Scale factor selected by a two-bit decimal exponent.
    function automatic logic [9:0] pow10(input logic [1:0] code);
        logic [9:0] f;
        case (code)
            2'd0:    f = 10'd1;
            2'd1:    f = 10'd10;
            2'd2:    f = 10'd100;
            default: f = 10'd1000;
        endcase
        return f;
    endfunction

    // Four nibbles weighted 1000, 100, 10 and 1.
    function automatic logic [14:0] nibble_value(input logic [7:0] hi, input logic [7:0] lo);
        logic [14:0] v;
        v = 15'(hi[7:4]) * 15'd1000 + 15'(hi[3:0]) * 15'd100
          + 15'(lo[7:4]) * 15'd10 + 15'(lo[3:0]);
        return v;
    endfunction

endpackage

[rtl/pmarc_front.sv]
// Front parser: walks the length-type records of the advertisement byte stream.
// Pushes each complete 8-byte manufacturer record into the queue. Uses pmarc_pkg.
module pmarc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    output logic            o_push,
    output pmarc_pkg::t_rec o_push_rec,
    input  logic            i_q_full
);
    import pmarc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_remaining, n_remaining;
    logic       r_mfr, n_mfr;
    logic       r_skip, n_skip;
    logic [7:0] r_rec [7];

    logic       w_accept;
    logic [2:0] w_idx;
    logic       w_push;

    // Stall only while the queue cannot take another record.
    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign w_idx      = 3'(MFR_LEN - r_remaining);

    // Parser next state for one transferred byte.
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_mfr       = r_mfr;
        n_skip      = r_skip;
        w_push      = 1'b0;
        if (w_accept) begin
            if (!r_skip) begin
                case (r_phase)
                    PH_TYPE: begin
                        if (i_data_byte == MFR_TYPE && r_remaining != MFR_LEN) begin
                            n_skip = 1'b1;
                        end else begin
                            n_mfr   = (i_data_byte == MFR_TYPE);
                            n_phase = (r_remaining == 8'd0) ? PH_LEN : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_remaining = r_remaining - 8'd1;
                        if (n_remaining == 8'd0) begin
                            w_push  = r_mfr;
                            n_mfr   = 1'b0;
                            n_phase = PH_LEN;
                        end
                    end
                    default: begin
                        // Length byte; a length of zero wraps around to a 255-byte body.
                        n_remaining = i_data_byte - 8'd1;
                        n_mfr       = 1'b0;
                        n_phase     = PH_TYPE;
                    end
                endcase
            end
            if (i_last_byte) begin
                n_phase     = PH_LEN;
                n_remaining = 8'd0;
                n_mfr       = 1'b0;
                n_skip      = 1'b0;
            end
        end
    end

    // Parser control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_remaining <= 8'd0;
            r_mfr       <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_mfr       <= n_mfr;
            r_skip      <= n_skip;
        end
    end

    // Record byte store; the eighth byte goes straight into the queue.
    always_ff @(posedge i_clk) begin
        if (w_accept && !r_skip && r_phase == PH_BODY && r_mfr && w_idx != 3'd7) begin
            r_rec[w_idx] <= i_data_byte;
        end
    end

    assign o_push = w_push;

    always_comb begin
        for (int k = 0; k < 7; k++) begin
            o_push_rec[k] = r_rec[k];
        end
        o_push_rec[7] = i_data_byte;
    end

endmodule

[rtl/pmarc_fifo.sv]
// Short record queue between the front parser and the back end.
// Register based, one push and one pop port. Uses pmarc_pkg.
module pmarc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pmarc_pkg::t_rec i_push_rec,
    output logic            o_full,
    input  logic            i_pop,
    output pmarc_pkg::t_rec o_pop_rec,
    output logic            o_empty
);
    import pmarc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    logic w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_pop_rec = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push_rec;
        end
    end

endmodule

[rtl/pmarc_back.sv]
// Back end: decodes one queued record and checks the reported wattage.
// A one-hot sequencer runs one multiply or compare per step. Uses pmarc_pkg.
module pmarc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    output logic            o_pop,
    input  pmarc_pkg::t_rec i_rec,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_accepted,
    output logic [7:0]      o_status_bits,
    output logic [7:0]      o_pf_pct,
    output logic [8:0]      o_voltage,
    output logic [23:0]     o_current,
    output logic [23:0]     o_wattage,
    output logic [31:0]     o_watt_calc
);
    import pmarc_pkg::*;

    t_back_state r_state;
    logic        r_out_valid;

    logic [7:0]  r_status, r_pf;
    logic [1:0]  r_cur_code, r_watt_code;
    logic [8:0]  r_volt;
    logic [23:0] r_cur, r_watt;
    logic [31:0] r_prod, r_check, r_diff;

    logic [27:0] w_volt_prod;
    logic [24:0] w_cur_scaled, w_watt_scaled;
    logic [32:0] w_vi;
    logic [39:0] w_vpf;
    logic [62:0] w_div;
    logic [31:0] w_watt32;
    logic [36:0] w_diff20;
    logic        w_ok;
    logic        w_load;

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // Datapath for each step.
    assign w_volt_prod   = 28'({i_rec[2][3:0], i_rec[3]}) * 28'(VOLT_RECIP);
    assign w_cur_scaled  = 25'(r_cur[14:0]) * 25'(pow10(r_cur_code));
    assign w_watt_scaled = 25'(r_watt[14:0]) * 25'(pow10(r_watt_code));
    assign w_vi          = 33'(r_volt) * 33'(r_cur);
    assign w_vpf         = 40'(r_prod) * 40'(r_pf);
    assign w_div         = 63'(r_prod) * 63'(DIV100_RECIP);
    assign w_watt32      = 32'(r_watt);
    // diff * 20 as (diff << 4) + (diff << 2).
    assign w_diff20      = {1'b0, r_diff, 4'b0} + {3'b0, r_diff, 2'b0};
    assign w_ok          = (r_watt != 24'd0) ? (w_diff20 < 37'(r_watt))
                                             : (r_check < ZERO_WATT_LIMIT);
    assign w_load        = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE:   if (!i_empty) r_state <= ST_SCALE;
                ST_SCALE:  r_state <= ST_MUL_VI;
                ST_MUL_VI: r_state <= ST_MUL_PF;
                ST_MUL_PF: r_state <= ST_DIV;
                ST_DIV:    r_state <= ST_DIFF;
                ST_DIFF:   r_state <= ST_DONE;
                ST_DONE:   if (w_load) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_status    <= i_rec[0];
                    r_pf        <= i_rec[1];
                    r_cur_code  <= i_rec[2][7:6];
                    r_watt_code <= i_rec[2][5:4];
                    r_volt      <= w_volt_prod[27:19];
                    r_cur       <= 24'(nibble_value(i_rec[4], i_rec[5]));
                    r_watt      <= 24'(nibble_value(i_rec[6], i_rec[7]));
                end
            end
            ST_SCALE: begin
                r_cur  <= w_cur_scaled[23:0];
                r_watt <= w_watt_scaled[23:0];
            end
            ST_MUL_VI: r_prod <= w_vi[31:0];
            ST_MUL_PF: r_prod <= w_vpf[31:0];
            ST_DIV:    r_check <= {6'b0, w_div[62:37]};
            ST_DIFF: begin
                r_diff <= (w_watt32 > r_check) ? (w_watt32 - r_check) : (r_check - w_watt32);
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_accepted    <= w_ok;
            o_status_bits <= r_status;
            o_pf_pct      <= r_pf;
            o_voltage     <= r_volt;
            o_current     <= r_cur;
            o_wattage     <= r_watt;
            o_watt_calc   <= r_check;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/power_meter_adv_record_checker.sv]
// Top level of the power meter advertisement record checker.
// Instantiates pmarc_front, pmarc_fifo and pmarc_back; uses pmarc_pkg.
//
// Usage:
// The input channel carries one advertisement payload byte per transfer, with
// i_last_byte marking the final byte. The byte stream is parsed as length-type
// records. Each complete 8-byte manufacturer record (type 0xFF) produces one
// result transfer on the output channel with the decoded fields and the
// wattage check; all other records produce nothing.
// Throughput: one byte per cycle. The front parser stalls only when the record
// queue is full. The back end spends seven sequencer steps per record (one
// multiply, divide-by-reciprocal or compare per step), pops no record before
// the last result is loaded, and keeps up with records at least ten bytes apart.
// With an idle back end, the record passes from the queue through the steps
// ST_SCALE to ST_DONE, and the result is then loaded into the output register.
// When the receiver stalls, the result is held in the output register, the
// back end waits with the next record finished, and the queue fills; the
// input then stalls once the queue is full.
// Reset (synchronous, active low) returns the parser to the length byte,
// empties the queue and drops any pending result. No clearing pass is needed.
module power_meter_adv_record_checker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [7:0]  o_status_bits,
    output logic [7:0]  o_pf_pct,
    output logic [8:0]  o_voltage,
    output logic [23:0] o_current,
    output logic [23:0] o_wattage,
    output logic [31:0] o_watt_calc
);
    import pmarc_pkg::*;

    logic w_push, w_full, w_pop, w_empty;
    t_rec w_push_rec, w_pop_rec;

    // Parser front end.
    pmarc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_push     (w_push),
        .o_push_rec (w_push_rec),
        .i_q_full   (w_full)
    );

    // Record queue.
    pmarc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_rec(w_push_rec),
        .o_full    (w_full),
        .i_pop     (w_pop),
        .o_pop_rec (w_pop_rec),
        .o_empty   (w_empty)
    );

    // Decode and check back end.
    pmarc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_rec        (w_pop_rec),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_status_bits(o_status_bits),
        .o_pf_pct     (o_pf_pct),
        .o_voltage    (o_voltage),
        .o_current    (o_current),
        .o_wattage    (o_wattage),
        .o_watt_calc  (o_watt_calc)
    );

endmodule

[rtl/pmarc_chk.sv]
// Port-level assertions for the power meter record checker, bound to the top level.
// Sees only the top-level ports; no package dependency.
module pmarc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_accepted,
    input logic [8:0]  o_voltage,
    input logic [23:0] o_current,
    input logic [23:0] o_wattage,
    input logic [31:0] o_watt_calc
);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result is held with its check value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_watt_calc))
        else $error("stalled result changed");

    // The voltage field is a 12-bit value divided by ten.
    a_volt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_voltage <= 9'd409)
        else $error("voltage out of range");

    // The current field never exceeds the largest scaled nibble value.
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_current <= 24'd16665000)
        else $error("current out of range");

    // With zero reported wattage, a check value of five or more is rejected.
    a_zero_watt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wattage == 24'd0 && o_watt_calc >= 32'd5 |-> !o_accepted)
        else $error("zero wattage accepted with large check value");

endmodule

bind power_meter_adv_record_checker pmarc_chk u_pmarc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_accepted (o_accepted),
    .o_voltage  (o_voltage),
    .o_current  (o_current),
    .o_wattage  (o_wattage),
    .o_watt_calc(o_watt_calc)
);

[test/power_meter_adv_record_checker_tb.sv]
// Testbench for power_meter_adv_record_checker: streams advertisement payloads and checks
// every decoded meter reading against a record parser and wattage check of its own.
// Depends on pmarc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module power_meter_adv_record_checker_tb;

    import pmarc_pkg::*;

    // One payload byte as it is presented on the input channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload_byte;

    // One decoded meter reading as it leaves the block.
    typedef struct packed {
        logic        accepted;
        logic [7:0]  status_bits;
        logic [7:0]  pf_pct;
        logic [8:0]  voltage;
        logic [23:0] current;
        logic [23:0] wattage;
        logic [31:0] watt_calc;
    } t_meter_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_accepted;
    logic [7:0]  o_status_bits;
    logic [7:0]  o_pf_pct;
    logic [8:0]  o_voltage;
    logic [23:0] o_current;
    logic [23:0] o_wattage;
    logic [31:0] o_watt_calc;

    power_meter_adv_record_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accepted    (o_accepted),
        .o_status_bits (o_status_bits),
        .o_pf_pct      (o_pf_pct),
        .o_voltage     (o_voltage),
        .o_current     (o_current),
        .o_wattage     (o_wattage),
        .o_watt_calc   (o_watt_calc)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and scoreboard storage.
    t_payload_byte  bytes_pending[$];
    logic [7:0]     adv_bytes[$];
    t_meter_reading readings_due[$];
    t_payload_byte  next_byte;

    // Parser state mirrored by the testbench.
    t_phase         parse_ph = PH_LEN;
    logic [7:0]     body_left = 8'd0;
    logic           in_meter_rec = 1'b0;
    logic           skipping = 1'b0;
    t_rec           meter_rec = '0;

    int unsigned errors = 0;
    int unsigned bytes_queued = 0;
    int unsigned adverts = 0;
    int unsigned readings_seen = 0;
    int unsigned readings_ok = 0;
    int unsigned gap_left = 0;
    int unsigned steady_left = 0;
    int unsigned stall_left = 0;
    logic        byte_taken = 1'b0;

    // Idle length: mostly none, sometimes a few cycles, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Four nibbles read as decimal digits, most significant first.
    function automatic int unsigned digit_sum(input logic [7:0] hi, input logic [7:0] lo);
        return hi[7:4] * 1000 + hi[3:0] * 100 + lo[7:4] * 10 + lo[3:0];
    endfunction

    function automatic int unsigned decade(input logic [1:0] code);
        case (code)
            2'd0:    return 1;
            2'd1:    return 10;
            2'd2:    return 100;
            default: return 1000;
        endcase
    endfunction

    // Four decimal digits of v packed as nibbles.
    function automatic logic [15:0] to_bcd(input int unsigned v);
        return {4'(v / 1000 % 10), 4'(v / 100 % 10), 4'(v / 10 % 10), 4'(v % 10)};
    endfunction

    // Decode a complete manufacturer record and run the wattage check.
    function automatic t_meter_reading decode_reading(input t_rec r);
        t_meter_reading m;
        logic [31:0]    cur32;
        logic [31:0]    watt32;
        logic [31:0]    prod;
        logic [31:0]    diff;
        m.status_bits = r[0];
        m.pf_pct      = r[1];
        m.voltage     = 9'({r[2][3:0], r[3]} / 10);
        cur32  = digit_sum(r[4], r[5]) * decade(r[2][7:6]);
        watt32 = digit_sum(r[6], r[7]) * decade(r[2][5:4]);
        m.current = cur32[23:0];
        m.wattage = watt32[23:0];
        prod = 32'(m.voltage) * cur32;
        prod = prod * 32'(m.pf_pct);
        m.watt_calc = prod / 100;
        diff = (watt32 > m.watt_calc) ? watt32 - m.watt_calc
                                      : m.watt_calc - watt32;
        if (watt32 != 0)
            m.accepted = (64'(diff) * 64'd20) < 64'(watt32);
        else
            m.accepted = m.watt_calc < ZERO_WATT_LIMIT;
        return m;
    endfunction

    // Advance the parser by one accepted payload byte; queue a reading when one completes.
    task automatic track_payload_byte(input logic [7:0] b, input logic last);
        if (!skipping) begin
            case (parse_ph)
                PH_TYPE: begin
                    if (b == MFR_TYPE && body_left != MFR_LEN) begin
                        skipping = 1'b1;
                    end else begin
                        in_meter_rec = (b == MFR_TYPE);
                        parse_ph = (body_left == 8'd0) ? PH_LEN : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (in_meter_rec)
                        meter_rec[3'(MFR_LEN - body_left)] = b;
                    body_left = body_left - 8'd1;
                    if (body_left == 8'd0) begin
                        if (in_meter_rec)
                            readings_due.push_back(decode_reading(meter_rec));
                        in_meter_rec = 1'b0;
                        parse_ph = PH_LEN;
                    end
                end
                default: begin
                    body_left = b - 8'd1;
                    in_meter_rec = 1'b0;
                    parse_ph = PH_TYPE;
                end
            endcase
        end
        // The final byte of an advertisement returns the parser to idle.
        if (last) begin
            parse_ph = PH_LEN;
            body_left = 8'd0;
            in_meter_rec = 1'b0;
            skipping = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Compare one result transfer with the oldest reading due.
    task automatic check_reading();
        t_meter_reading want;
        if (readings_due.size() == 0) begin
            $error("result transfer with no meter reading due");
            errors++;
        end else begin
            want = readings_due.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(o_accepted));
            compare_field("status_bits", 32'(want.status_bits), 32'(o_status_bits));
            compare_field("pf_pct", 32'(want.pf_pct), 32'(o_pf_pct));
            compare_field("voltage", 32'(want.voltage), 32'(o_voltage));
            compare_field("current", 32'(want.current), 32'(o_current));
            compare_field("wattage", 32'(want.wattage), 32'(o_wattage));
            compare_field("watt_calc", want.watt_calc, o_watt_calc);
        end
        readings_seen++;
        if (o_accepted === 1'b1)
            readings_ok++;
    endtask

    // Append a complete 8-byte manufacturer record to the advertisement being built.
    task automatic add_meter_record(input t_rec body);
        int k;
        adv_bytes.push_back(MFR_LEN + 8'd1);
        adv_bytes.push_back(MFR_TYPE);
        for (k = 0; k < 8; k++)
            adv_bytes.push_back(body[k]);
    endtask

    // Meter record with realistic values whose wattage is usually made to match the check,
    // or one with random content.
    task automatic add_random_meter_record(input bit plausible);
        t_rec        body;
        logic [11:0] vraw;
        logic [1:0]  cexp;
        logic [1:0]  wexp;
        int unsigned cval;
        int unsigned watt;
        logic [15:0] cbcd;
        logic [15:0] wbcd;
        logic [31:0] check;
        if (plausible) begin
            vraw = 12'($urandom_range(900, 2600));
            cexp = 2'($urandom_range(0, 1));
            cval = $urandom_range(0, 9999);
            body[0] = 8'($urandom);
            body[1] = 8'($urandom_range(40, 100));
            check = 32'(vraw / 10) * 32'(cval * decade(cexp));
            check = check * 32'(body[1]) / 100;
            wexp = 2'd0;
            watt = check;
            while (watt > 9999 && wexp < 2'd3) begin
                watt = watt / 10;
                wexp = wexp + 2'd1;
            end
            if (watt > 9999)
                watt = 9999;
            // Now and then shift the wattage by a multiple of ten so the check can fail on a sane record.
            if ($urandom_range(0, 9) == 0)
                watt = (watt + 10 * $urandom_range(1, 200)) % 10000;
            cbcd = to_bcd(cval);
            wbcd = to_bcd(watt);
            body[2] = {cexp, wexp, vraw[11:8]};
            body[3] = vraw[7:0];
            body[4] = cbcd[15:8];
            body[5] = cbcd[7:0];
            body[6] = wbcd[15:8];
            body[7] = wbcd[7:0];
        end else begin
            body = {$urandom, $urandom};
            // Zero current or wattage exercises the zero-wattage rule.
            if ($urandom_range(0, 3) == 0)
                {body[6], body[7]} = 16'h0000;
            if ($urandom_range(0, 3) == 0)
                {body[4], body[5]} = 16'h0000;
        end
        add_meter_record(body);
    endtask

    // Record of another type; length 1 has an empty body and length 0 wraps to 255.
    task automatic add_other_record(input logic [7:0] len);
        int k;
        adv_bytes.push_back(len);
        adv_bytes.push_back(8'($urandom_range(0, 254)));
        for (k = 0; k < int'(8'(len - 8'd1)); k++)
            adv_bytes.push_back(8'($urandom));
    endtask

    // Manufacturer record of the wrong size followed by bytes the parser ignores.
    task automatic add_bad_meter_record();
        logic [7:0] len;
        int         k;
        int         fill;
        len = 8'($urandom_range(0, 255));
        if (len == MFR_LEN + 8'd1)
            len = len + 8'd1;
        adv_bytes.push_back(len);
        adv_bytes.push_back(MFR_TYPE);
        fill = $urandom_range(0, 5);
        for (k = 0; k < fill; k++)
            adv_bytes.push_back(8'($urandom));
    endtask

    // Queue the advertisement built so far, optionally cut short at a random byte.
    task automatic close_adv(input bit cut);
        int n;
        int k;
        n = adv_bytes.size();
        if (cut && n > 1)
            n = $urandom_range(1, n - 1);
        for (k = 0; k < n; k++)
            bytes_pending.push_back('{adv_bytes[k], k == n - 1});
        bytes_queued += n;
        adverts++;
        adv_bytes.delete();
    endtask

    // Input driver: presents the next payload byte at the falling edge and
    // holds it until the transfer completes.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !byte_taken) begin
                // Stalled: payload stays put.
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (bytes_pending.size() > 0) begin
                next_byte = bytes_pending.pop_front();
                i_in_valid <= 1'b1;
                i_data_byte <= next_byte.data;
                i_last_byte <= next_byte.last;
                if (steady_left > 0) begin
                    gap_left <= 0;
                    steady_left <= steady_left - 1;
                end else begin
                    gap_left <= pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        steady_left <= $urandom_range(20, 80);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall: short and long stalls mixed with free-running stretches.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else if (!i_out_stall && $urandom_range(0, 99) < 35) begin
                i_out_stall <= 1'b1;
                stall_left <= pick_gap();
            end else begin
                i_out_stall <= 1'b0;
                stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
                                                           : $urandom_range(0, 12);
            end
        end
    end

    // Monitor: tracks every input transfer and checks every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            byte_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                track_payload_byte(i_data_byte, i_last_byte);
            if (o_out_valid && !i_out_stall)
                check_reading();
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int j;
        int nrec;
        int r;
        int k;

        // Empty-body record, all-zero and all-ones meter records in one advertisement.
        add_other_record(8'd1);
        add_meter_record('0);
        add_meter_record('1);
        close_adv(1'b0);
        // Wrong-size manufacturer record: the rest of the advertisement is ignored.
        adv_bytes.push_back(8'd3);
        adv_bytes.push_back(MFR_TYPE);
        adv_bytes.push_back(8'hAA);
        close_adv(1'b0);
        // Advertisements ending on a length byte, a type byte and inside a body.
        adv_bytes.push_back(8'd5);
        close_adv(1'b0);
        adv_bytes.push_back(MFR_LEN + 8'd1);
        adv_bytes.push_back(MFR_TYPE);
        close_adv(1'b0);
        adv_bytes.push_back(MFR_LEN + 8'd1);
        adv_bytes.push_back(MFR_TYPE);
        adv_bytes.push_back(8'h11);
        adv_bytes.push_back(8'h22);
        adv_bytes.push_back(8'h33);
        close_adv(1'b0);

        // Random advertisements, mostly well-formed record sequences.
        while (bytes_queued < 950) begin
            nrec = $urandom_range(1, 4);
            for (j = 0; j < nrec; j++) begin
                r = $urandom_range(0, 999);
                if (r < 400) begin
                    add_random_meter_record(1'b1);
                end else if (r < 600) begin
                    add_random_meter_record(1'b0);
                end else if (r < 780) begin
                    add_other_record(8'($urandom_range(2, 12)));
                end else if (r < 860) begin
                    add_other_record(8'd1);
                end else if (r < 865) begin
                    add_other_record(8'd0);
                end else if (r < 930) begin
                    add_bad_meter_record();
                    break;
                end else begin
                    for (k = $urandom_range(1, 3); k > 0; k--)
                        adv_bytes.push_back(8'($urandom));
                end
            end
            close_adv($urandom_range(0, 99) < 12);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all bytes sent, all readings back, then a latency's worth of quiet.
        while (bytes_pending.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (readings_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (readings_due.size() != 0) begin
            $error("%0d meter readings never arrived", readings_due.size());
            errors++;
        end

        $display("Sent %0d payload bytes in %0d advertisements with random gaps and stalls.",
                 bytes_queued, adverts);
        $display("Checked %0d meter readings, %0d accepted and %0d rejected.",
                 readings_seen, readings_ok, readings_seen - readings_ok);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/pmarc_pkg.sv
rtl/pmarc_front.sv
rtl/pmarc_fifo.sv
rtl/pmarc_back.sv
rtl/power_meter_adv_record_checker.sv
rtl/pmarc_chk.sv
test/power_meter_adv_record_checker_tb.sv
